@@ rtl/tvs_pkg.sv @@
// Shared types, codes and helper functions of the typed variable store.
`default_nettype none
package tvs_pkg;

    localparam int TABLE_ENTRIES_DEF = 64;
    localparam int NAME_BYTES_DEF    = 8;
    localparam int MEM_BYTES_DEF     = 65536;

    // Base addresses are carried at the width of the largest supported memory.
    localparam int BASE_W = 24;

    typedef enum logic [1:0] {
        CMD_CREATE_VAR = 2'd0,
        CMD_CREATE_ARR = 2'd1,
        CMD_ASSIGN     = 2'd2,
        CMD_READ       = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        KIND_INT32 = 2'd0,
        KIND_INT8  = 2'd1,
        KIND_INT24 = 2'd2,
        KIND_BOOL  = 2'd3
    } kind_t;

    typedef enum logic [2:0] {
        STS_OK          = 3'd0,
        STS_NO_SPACE    = 3'd1,
        STS_TABLE_FULL  = 3'd2,
        STS_NOT_FOUND   = 3'd3,
        STS_VALUE_RANGE = 3'd4,
        STS_INDEX_RANGE = 3'd5
    } status_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CREATE,
        ST_SEARCH,
        ST_CHECK,
        ST_WRITE,
        ST_RD_ISSUE,
        ST_RD_WAIT,
        ST_DONE
    } state_t;

    // One row of the name table.
    typedef struct packed {
        logic [63:0]       name;
        kind_t             kind;
        logic [15:0]       length;
        logic [BASE_W-1:0] base;
    } entry_t;

    localparam logic signed [63:0] INT32_MIN = -64'sd2147483648;
    localparam logic signed [63:0] INT32_MAX = 64'sd2147483647;
    localparam logic signed [63:0] INT8_MIN  = -64'sd128;
    localparam logic signed [63:0] INT8_MAX  = 64'sd127;
    localparam logic signed [63:0] INT24_MIN = -64'sd8388608;
    localparam logic signed [63:0] INT24_MAX = 64'sd8388607;

    function automatic logic [2:0] elem_size(input kind_t kind);
        logic [2:0] sz;
        unique case (kind)
            KIND_INT32: sz = 3'd4;
            KIND_INT24: sz = 3'd3;
            KIND_INT8:  sz = 3'd1;
            KIND_BOOL:  sz = 3'd1;
            default:    sz = 3'd1;
        endcase
        return sz;
    endfunction

    // Element count times element size, in bytes.
    function automatic logic [17:0] scaled(input kind_t kind, input logic [15:0] n);
        logic [17:0] r;
        unique case (kind)
            KIND_INT32: r = {n, 2'b00};
            KIND_INT24: r = {2'b00, n} + {1'b0, n, 1'b0};
            KIND_INT8:  r = {2'b00, n};
            KIND_BOOL:  r = {2'b00, n};
            default:    r = {2'b00, n};
        endcase
        return r;
    endfunction

    function automatic logic value_fits(input kind_t kind, input logic signed [63:0] v);
        logic ok;
        unique case (kind)
            KIND_INT32: ok = (v >= INT32_MIN) && (v <= INT32_MAX);
            KIND_INT8:  ok = (v >= INT8_MIN) && (v <= INT8_MAX);
            KIND_INT24: ok = (v >= INT24_MIN) && (v <= INT24_MAX);
            KIND_BOOL:  ok = (v == 64'sd0) || (v == 64'sd1);
            default:    ok = 1'b0;
        endcase
        return ok;
    endfunction

endpackage
`default_nettype wire

@@ rtl/tvs_table.sv @@
// Name table memory: one entry per row, synchronous read.
`default_nettype none
module tvs_table
    import tvs_pkg::*;
#(
    parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF,
    parameter int TW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1
)
(
    input  wire logic          clk,
    input  wire logic          we,
    input  wire logic [TW-1:0] addr,
    input  wire entry_t        wdata,
    output entry_t             rdata
);

    entry_t mem [TABLE_ENTRIES];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule
`default_nettype wire

@@ rtl/tvs_data.sv @@
// Byte-wide data memory holding element values, synchronous read.
`default_nettype none
module tvs_data
    import tvs_pkg::*;
#(
    parameter int MEM_BYTES = MEM_BYTES_DEF,
    parameter int AW = $clog2(MEM_BYTES)
)
(
    input  wire logic          clk,
    input  wire logic          we,
    input  wire logic [AW-1:0] addr,
    input  wire logic [7:0]    wdata,
    output logic [7:0]         rdata
);

    logic [7:0] mem [MEM_BYTES];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule
`default_nettype wire

@@ rtl/tvs_ctrl.sv @@
// Sequencer: create, lookup walk, range checks and byte-serial element access.
`default_nettype none
module tvs_ctrl
    import tvs_pkg::*;
#(
    parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF,
    parameter int NAME_BYTES    = NAME_BYTES_DEF,
    parameter int MEM_BYTES     = MEM_BYTES_DEF,
    parameter int TW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1,
    parameter int AW = $clog2(MEM_BYTES)
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire cmd_t               in_cmd,
    input  wire logic [63:0]        in_name,
    input  wire kind_t              in_kind,
    input  wire logic [15:0]        in_count,
    input  wire logic [15:0]        in_index,
    input  wire logic signed [63:0] in_value,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output status_t                 out_status,
    output logic [31:0]             out_value,
    output logic                    out_kind,
    output logic [15:0]             out_base,
    output logic                    tbl_we,
    output logic [TW-1:0]           tbl_addr,
    output entry_t                  tbl_wdata,
    input  wire entry_t             tbl_rdata,
    output logic                    dat_we,
    output logic [AW-1:0]           dat_addr,
    output logic [7:0]              dat_wdata,
    input  wire logic [7:0]         dat_rdata
);

    localparam int CW     = $clog2(TABLE_ENTRIES + 1);
    localparam int FW     = AW + 1;
    localparam int SW     = (FW > 19) ? FW : 19;
    localparam int USABLE = (MEM_BYTES / 4) * 4;

    state_t             state_reg, state_next;
    cmd_t               cmd_reg, cmd_next;
    logic [63:0]        name_reg, name_next;
    kind_t              kind_reg, kind_next;
    logic [15:0]        count_reg, count_next;
    logic [15:0]        index_reg, index_next;
    logic signed [63:0] value_reg, value_next;
    logic [CW-1:0]      used_reg, used_next;
    logic [FW-1:0]      free_reg, free_next;
    logic [CW-1:0]      ptr_reg, ptr_next;
    logic               cmpv_reg, cmpv_next;
    entry_t             ent_reg, ent_next;
    logic [AW-1:0]      addr_reg, addr_next;
    logic [1:0]         byte_reg, byte_next;
    logic [31:0]        raw_reg, raw_next;
    status_t            rs_status_reg, rs_status_next;
    logic [31:0]        rs_value_reg, rs_value_next;
    logic               rs_kind_reg, rs_kind_next;
    logic [15:0]        rs_base_reg, rs_base_next;
    logic               ov_reg, ov_next;
    status_t            os_reg, os_next;
    logic [31:0]        oval_reg, oval_next;
    logic               okind_reg, okind_next;
    logic [15:0]        obase_reg, obase_next;

    logic [63:0] clean_name;
    logic        keep;
    logic [15:0] n_w;
    logic [18:0] sum_w;
    logic [SW-1:0] need_w, room_w;
    logic [17:0] offs_w;
    logic [2:0]  sz_w;
    logic        last_w;
    logic [31:0] raw_w;

    // Names end at the first zero byte or after NAME_BYTES bytes.
    always_comb
    begin
        clean_name = '0;
        keep = 1'b1;
        for (int i = 0; i < 8; i++)
        begin
            keep = keep && (i < NAME_BYTES) && (in_name[i*8 +: 8] != 8'd0);
            clean_name[i*8 +: 8] = keep ? in_name[i*8 +: 8] : 8'd0;
        end
    end

    always_comb
    begin
        n_w    = (cmd_reg == CMD_CREATE_VAR) ? 16'd1 : count_reg;
        sum_w  = {1'b0, scaled(kind_reg, n_w)} + 19'd3;
        need_w = SW'({sum_w[18:2], 2'b00});
        room_w = SW'(USABLE) - SW'(free_reg);
        offs_w = scaled(ent_reg.kind, index_reg);
        sz_w   = elem_size(ent_reg.kind);
        last_w = (byte_reg == 2'(sz_w - 3'd1));
    end

    always_comb
    begin
        state_next     = state_reg;
        cmd_next       = cmd_reg;
        name_next      = name_reg;
        kind_next      = kind_reg;
        count_next     = count_reg;
        index_next     = index_reg;
        value_next     = value_reg;
        used_next      = used_reg;
        free_next      = free_reg;
        ptr_next       = ptr_reg;
        cmpv_next      = cmpv_reg;
        ent_next       = ent_reg;
        addr_next      = addr_reg;
        byte_next      = byte_reg;
        raw_next       = raw_reg;
        rs_status_next = rs_status_reg;
        rs_value_next  = rs_value_reg;
        rs_kind_next   = rs_kind_reg;
        rs_base_next   = rs_base_reg;
        ov_next        = ov_reg && !out_ready;
        os_next        = os_reg;
        oval_next      = oval_reg;
        okind_next     = okind_reg;
        obase_next     = obase_reg;
        raw_w          = raw_reg;
        in_ready       = (state_reg == ST_IDLE);
        tbl_we         = 1'b0;
        tbl_addr       = ptr_reg[TW-1:0];
        tbl_wdata      = '{name: name_reg, kind: kind_reg, length: n_w,
                           base: BASE_W'(free_reg)};
        dat_we         = 1'b0;
        dat_addr       = addr_reg + AW'(byte_reg);
        dat_wdata      = value_reg[byte_reg*8 +: 8];

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd_next       = in_cmd;
                    name_next      = clean_name;
                    kind_next      = in_kind;
                    count_next     = in_count;
                    index_next     = in_index;
                    value_next     = in_value;
                    ptr_next       = '0;
                    cmpv_next      = 1'b0;
                    byte_next      = '0;
                    raw_next       = '0;
                    rs_status_next = STS_OK;
                    rs_value_next  = '0;
                    rs_kind_next   = 1'b0;
                    rs_base_next   = '0;
                    if (in_cmd == CMD_CREATE_VAR || in_cmd == CMD_CREATE_ARR)
                    begin
                        state_next = ST_CREATE;
                    end
                    else
                    begin
                        state_next = ST_SEARCH;
                    end
                end
            end
            ST_CREATE:
            begin
                tbl_addr = used_reg[TW-1:0];
                if (used_reg >= CW'(TABLE_ENTRIES))
                begin
                    rs_status_next = STS_TABLE_FULL;
                end
                else if (need_w > room_w)
                begin
                    rs_status_next = STS_NO_SPACE;
                end
                else
                begin
                    tbl_we       = 1'b1;
                    rs_base_next = 16'(free_reg);
                    free_next    = FW'(SW'(free_reg) + need_w);
                    used_next    = used_reg + CW'(1);
                end
                state_next = ST_DONE;
            end
            ST_SEARCH:
            begin
                if (cmpv_reg && tbl_rdata.name == name_reg)
                begin
                    ent_next   = tbl_rdata;
                    state_next = ST_CHECK;
                end
                else if (!cmpv_reg && ptr_reg >= used_reg)
                begin
                    rs_status_next = STS_NOT_FOUND;
                    state_next     = ST_DONE;
                end
                else
                begin
                    cmpv_next = (ptr_reg < used_reg);
                    if (ptr_reg < used_reg)
                    begin
                        ptr_next = ptr_reg + CW'(1);
                    end
                end
            end
            ST_CHECK:
            begin
                if (index_reg >= ent_reg.length)
                begin
                    rs_status_next = STS_INDEX_RANGE;
                    state_next     = ST_DONE;
                end
                else if (cmd_reg == CMD_ASSIGN && !value_fits(ent_reg.kind, value_reg))
                begin
                    rs_status_next = STS_VALUE_RANGE;
                    state_next     = ST_DONE;
                end
                else
                begin
                    addr_next  = AW'(ent_reg.base + BASE_W'(offs_w));
                    state_next = (cmd_reg == CMD_ASSIGN) ? ST_WRITE : ST_RD_ISSUE;
                end
            end
            ST_WRITE:
            begin
                dat_we = 1'b1;
                if (last_w)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    byte_next = byte_reg + 2'd1;
                end
            end
            ST_RD_ISSUE:
            begin
                state_next = ST_RD_WAIT;
            end
            ST_RD_WAIT:
            begin
                raw_w[byte_reg*8 +: 8] = dat_rdata;
                raw_next = raw_w;
                if (last_w)
                begin
                    unique case (ent_reg.kind)
                        KIND_INT8:  rs_value_next = {{24{raw_w[7]}}, raw_w[7:0]};
                        KIND_INT24: rs_value_next = {{8{raw_w[23]}}, raw_w[23:0]};
                        KIND_INT32: rs_value_next = raw_w;
                        KIND_BOOL:  rs_value_next = {24'd0, raw_w[7:0]};
                        default:    rs_value_next = raw_w;
                    endcase
                    rs_kind_next = (ent_reg.kind == KIND_INT8);
                    state_next   = ST_DONE;
                end
                else
                begin
                    byte_next  = byte_reg + 2'd1;
                    state_next = ST_RD_ISSUE;
                end
            end
            ST_DONE:
            begin
                if (!ov_reg || out_ready)
                begin
                    ov_next    = 1'b1;
                    os_next    = rs_status_reg;
                    oval_next  = rs_value_reg;
                    okind_next = rs_kind_reg;
                    obase_next = rs_base_reg;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            used_reg  <= '0;
            free_reg  <= '0;
            ov_reg    <= 1'b0;
            cmpv_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            used_reg  <= used_next;
            free_reg  <= free_next;
            ov_reg    <= ov_next;
            cmpv_reg  <= cmpv_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg       <= cmd_next;
        name_reg      <= name_next;
        kind_reg      <= kind_next;
        count_reg     <= count_next;
        index_reg     <= index_next;
        value_reg     <= value_next;
        ptr_reg       <= ptr_next;
        ent_reg       <= ent_next;
        addr_reg      <= addr_next;
        byte_reg      <= byte_next;
        raw_reg       <= raw_next;
        rs_status_reg <= rs_status_next;
        rs_value_reg  <= rs_value_next;
        rs_kind_reg   <= rs_kind_next;
        rs_base_reg   <= rs_base_next;
        os_reg        <= os_next;
        oval_reg      <= oval_next;
        okind_reg     <= okind_next;
        obase_reg     <= obase_next;
    end

    assign out_valid  = ov_reg;
    assign out_status = os_reg;
    assign out_value  = oval_reg;
    assign out_kind   = okind_reg;
    assign out_base   = obase_reg;

`ifndef SYNTHESIS
    a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
        used_reg <= CW'(TABLE_ENTRIES))
        else $error("table fill count beyond table size");
    a_free_bound: assert property (@(posedge clk) disable iff (!rst_n)
        SW'(free_reg) <= SW'(USABLE) && free_reg[1:0] == 2'b00)
        else $error("free pointer beyond usable area or misaligned");
    a_no_write_fail: assert property (@(posedge clk) disable iff (!rst_n)
        dat_we |-> (state_reg == ST_WRITE && rs_status_reg == STS_OK))
        else $error("data write outside a valid assign");
    a_used_step: assert property (@(posedge clk) disable iff (!rst_n)
        (used_reg != $past(used_reg)) |-> ($past(state_reg) == ST_CREATE))
        else $error("table fill count changed outside a create");
`endif

endmodule
`default_nettype wire

@@ rtl/typed_variable_store.sv @@
// Top level of the typed variable store: stream ports, sequencer and memories.
`default_nettype none
// A word on the input stream carries one command: create a variable, create
// an array, assign one element or read one element back; each command gives
// exactly one result word. Names (up to NAME_BYTES bytes, ending at the first
// zero byte) sit in a name table memory that is searched from the oldest
// entry, so the first match wins. Storage comes from one word-aligned region
// that only grows; it is never returned. A create checks and writes the table
// row, then loads the result register. Assign and read walk the name table
// one entry per cycle through its synchronous read port, from position zero
// up to the hit or past the last used entry. After a hit come the index and
// value checks, the element access in the byte-wide data memory (each byte
// written in turn, or issued and then captured for a read, up to 4 bytes),
// and the load of the result register, which waits while an earlier result
// is still held downstream. The longest command is a 4-byte read of the last
// entry of a full 64-entry table. One command is in work at a time; the
// input is ready again in the cycle its result appears, and the result
// register lets the next command be taken while a result still waits
// downstream. Elements that were never assigned read back unspecified data.
module typed_variable_store
    import tvs_pkg::*;
#(
    parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF,
    parameter int NAME_BYTES    = NAME_BYTES_DEF,
    parameter int MEM_BYTES     = MEM_BYTES_DEF
)
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    // var_name[63:0], elem_type[65:64], elem_count[81:66],
    // elem_index[97:82], new_value[161:98], zero fill [167:162]
    input  wire logic [167:0] s_axis_tdata,
    // command[1:0]
    input  wire logic [1:0]   s_axis_tuser,
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    // status[2:0], read_value[34:3], base_address[50:35], zero fill [55:51]
    output logic [55:0]       m_axis_tdata,
    // value_kind[0]
    output logic              m_axis_tuser
);

    localparam int TW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int AW = $clog2(MEM_BYTES);

    logic          tbl_we;
    logic [TW-1:0] tbl_addr;
    entry_t        tbl_wdata, tbl_rdata;
    logic          dat_we;
    logic [AW-1:0] dat_addr;
    logic [7:0]    dat_wdata, dat_rdata;
    status_t       res_status;
    logic [31:0]   res_value;
    logic [15:0]   res_base;

    // The sequencer owns all control state and the result register.
    tvs_ctrl #(
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .NAME_BYTES    (NAME_BYTES),
        .MEM_BYTES     (MEM_BYTES),
        .TW            (TW),
        .AW            (AW)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .in_cmd     (cmd_t'(s_axis_tuser)),
        .in_name    (s_axis_tdata[63:0]),
        .in_kind    (kind_t'(s_axis_tdata[65:64])),
        .in_count   (s_axis_tdata[81:66]),
        .in_index   (s_axis_tdata[97:82]),
        .in_value   ($signed(s_axis_tdata[161:98])),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_status (res_status),
        .out_value  (res_value),
        .out_kind   (m_axis_tuser),
        .out_base   (res_base),
        .tbl_we     (tbl_we),
        .tbl_addr   (tbl_addr),
        .tbl_wdata  (tbl_wdata),
        .tbl_rdata  (tbl_rdata),
        .dat_we     (dat_we),
        .dat_addr   (dat_addr),
        .dat_wdata  (dat_wdata),
        .dat_rdata  (dat_rdata)
    );

    // Name table: name, type, length and base of each entry.
    tvs_table #(
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .TW            (TW)
    ) u_table (
        .clk   (clk),
        .we    (tbl_we),
        .addr  (tbl_addr),
        .wdata (tbl_wdata),
        .rdata (tbl_rdata)
    );

    // Element bytes, little-endian within an element.
    tvs_data #(
        .MEM_BYTES (MEM_BYTES),
        .AW        (AW)
    ) u_data (
        .clk   (clk),
        .we    (dat_we),
        .addr  (dat_addr),
        .wdata (dat_wdata),
        .rdata (dat_rdata)
    );

    assign m_axis_tdata = {5'd0, res_base, res_value, res_status};

endmodule
`default_nettype wire
